@@ sv/tccw_pkg.sv @@
// Package for the text console character writer.
// Holds field widths, opcodes, character codes and the controller state type.
// No dependencies.
`default_nettype none

package tccw_pkg;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 11;
  localparam int CELL_W = 2 * CHAR_W;

  localparam logic [OP_W-1:0] OP_PUT_CHAR   = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_CURSOR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_CELL  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_FIRST   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_LAST    = 8'h7F;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'd7;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_COPY  = 5'b01000,
    S_DIV   = 5'b10000
  } ctrl_state_t;

endpackage

`default_nettype wire

@@ sv/text_console_char_writer_core.sv @@
// Results for put-char, newline and set-cursor are registered at accept; read-cell results in S_READ.
// Put-char, plain newline and ignored bytes: 1 beat per cycle unless out_ready holds results back;
// read-cell passes S_READ; set-cursor passes S_DIV (column recovery by reciprocal multiply, then
// multiply-back and subtract); a scrolling newline passes S_COPY (row copy through the cell RAM port),
// then S_CLEAR (last row zeroed); in_ready is low in each. Reset: synchronous; a clearing pass
// zeroes the screen with in_ready low; cursor goes to 0, attribute to 7.
// Top level of the text console character writer; uses tccw_pkg.
`default_nettype none

module text_console_char_writer_core
  import tccw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CHAR_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   opcode,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [POS_W-1:0]  cell_position,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [POS_W-1:0]  cursor_after,
  output logic [CHAR_W-1:0] read_char,
  output logic [CHAR_W-1:0] read_attr,
  output logic              scrolled,
  output logic              write_dropped
);

  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int LAST_ROW_START = SCREEN_COLUMNS * (SCREEN_ROWS - 1);
  localparam int ADDR_W         = $clog2(CELL_COUNT);
  localparam int CURSOR_W       = $clog2(CELL_COUNT + 1);
  localparam int CMP_W          = (CURSOR_W > POS_W) ? CURSOR_W : POS_W;
  localparam int COL_W          = $clog2(SCREEN_COLUMNS);
  localparam int QW             = $clog2(SCREEN_ROWS + 1);
  localparam int RECIP_SH       = CURSOR_W + COL_W;
  localparam int RECIP_C        = ((1 << RECIP_SH) + SCREEN_COLUMNS - 1) / SCREEN_COLUMNS;
  localparam int RECIP_W        = $clog2(RECIP_C + 1);
  localparam int PROD_W         = CURSOR_W + RECIP_W;

  localparam logic [CURSOR_W-1:0] CELLS_C     = CURSOR_W'(CELL_COUNT);
  localparam logic [CURSOR_W-1:0] LAST_CELL_C = CURSOR_W'(CELL_COUNT - 1);
  localparam logic [CURSOR_W-1:0] LAST_ROW_C  = CURSOR_W'(LAST_ROW_START);
  localparam logic [CURSOR_W-1:0] COLS_C      = CURSOR_W'(SCREEN_COLUMNS);
  localparam logic [COL_W-1:0]    LAST_COL_C  = COL_W'(SCREEN_COLUMNS - 1);

  ctrl_state_t state, state_next;

  logic [CURSOR_W-1:0] sweep;
  logic [CURSOR_W-1:0] cursor, cursor_next;
  logic [COL_W-1:0]    col, col_next;
  logic [CHAR_W-1:0]   attr;
  logic [CURSOR_W-1:0] div_rem;
  logic [QW-1:0]       div_quot;
  logic                div_step;
  logic                rd_in_range;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] mem_rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  logic                accept;
  logic                is_print;
  logic                is_newline;
  logic                cur_room;
  logic [CMP_W-1:0]    pos_ext;
  logic [CURSOR_W-1:0] pos_sat;
  logic                pos_in_range;
  logic [CURSOR_W-1:0] copy_waddr;
  logic [PROD_W-1:0]   div_prod;
  logic [CURSOR_W-1:0] div_back;
  logic                res_scrolled;
  logic                res_dropped;
  logic [CMP_W-1:0]    cursor_out_ext;

  assign in_ready     = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept       = in_valid && in_ready;
  assign is_print     = char_code inside {[CHAR_FIRST:CHAR_LAST]};
  assign is_newline   = (char_code == NEWLINE_CHAR);
  assign cur_room     = (cursor < CELLS_C);
  assign pos_ext      = CMP_W'(cell_position);
  assign pos_in_range = (pos_ext < CMP_W'(CELL_COUNT));
  assign pos_sat      = (pos_ext > CMP_W'(CELL_COUNT)) ? CELLS_C : pos_ext[CURSOR_W-1:0];
  assign copy_waddr   = sweep - COLS_C - CURSOR_W'(1);

  assign div_prod = PROD_W'(div_rem) * PROD_W'(RECIP_C);
  assign div_back = CURSOR_W'(div_quot) * COLS_C;

  always_comb begin
    state_next   = S_IDLE;
    cursor_next  = cursor;
    col_next     = col;
    res_scrolled = 1'b0;
    res_dropped  = 1'b0;
    case (opcode)
      OP_PUT_CHAR: begin
        if (is_print) begin
          if (cur_room) begin
            cursor_next = cursor + CURSOR_W'(1);
            col_next    = (col == LAST_COL_C) ? '0 : col + COL_W'(1);
          end else begin
            res_dropped = 1'b1;
          end
        end else if (is_newline) begin
          col_next = '0;
          if (cursor >= LAST_ROW_C) begin
            cursor_next  = LAST_ROW_C;
            res_scrolled = 1'b1;
            state_next   = S_COPY;
          end else begin
            cursor_next = cursor - CURSOR_W'(col) + COLS_C;
          end
        end
      end
      OP_SET_CURSOR: begin
        cursor_next = pos_sat;
        state_next  = S_DIV;
      end
      OP_READ_CELL: begin
        state_next = S_READ;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign cursor_out_ext = CMP_W'(cursor_next);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cursor[ADDR_W-1:0];
    mem_wdata = {attr, char_code};
    mem_raddr = pos_ext[ADDR_W-1:0];
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep[ADDR_W-1:0];
        mem_wdata = '0;
      end
      S_IDLE: begin
        mem_we = accept && (opcode == OP_PUT_CHAR) && is_print && cur_room;
      end
      S_COPY: begin
        mem_we    = (sweep != COLS_C);
        mem_waddr = copy_waddr[ADDR_W-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = sweep[ADDR_W-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      sweep     <= '0;
      cursor    <= '0;
      col       <= '0;
      attr      <= ATTR_RESET;
      out_valid <= 1'b0;
      div_step  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        attr <= cfg_wr_data;
      end
      if (out_valid && out_ready && !accept) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (sweep == LAST_CELL_C) begin
            state <= S_IDLE;
          end else begin
            sweep <= sweep + CURSOR_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            state         <= state_next;
            cursor        <= cursor_next;
            col           <= col_next;
            sweep         <= COLS_C;
            div_rem       <= pos_sat;
            div_step      <= 1'b1;
            rd_in_range   <= pos_in_range;
            out_valid     <= (state_next != S_READ);
            cursor_after  <= cursor_out_ext[POS_W-1:0];
            read_char     <= '0;
            read_attr     <= '0;
            scrolled      <= res_scrolled;
            write_dropped <= res_dropped;
          end
        end
        S_READ: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
          read_char <= rd_in_range ? mem_rdata[CHAR_W-1:0] : '0;
          read_attr <= rd_in_range ? mem_rdata[CELL_W-1:CHAR_W] : '0;
        end
        S_COPY: begin
          if (sweep == CELLS_C) begin
            state <= S_CLEAR;
            sweep <= LAST_ROW_C;
          end else begin
            sweep <= sweep + CURSOR_W'(1);
          end
        end
        S_DIV: begin
          if (div_step) begin
            div_quot <= QW'(div_prod >> RECIP_SH);
            div_step <= 1'b0;
          end else begin
            col   <= COL_W'(div_rem - div_back);
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/tccw_checker.sv @@
// Port-level checker for the text console character writer, with its bind.
// Depends on tccw_pkg and text_console_char_writer_core.
`default_nettype none

module tccw_checker
  import tccw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [OP_W-1:0]   opcode,
  input logic [CHAR_W-1:0] char_code,
  input logic              out_valid,
  input logic              out_ready,
  input logic [POS_W-1:0]  cursor_after,
  input logic [CHAR_W-1:0] read_char,
  input logic [CHAR_W-1:0] read_attr,
  input logic              scrolled,
  input logic              write_dropped
);

  localparam logic [POS_W-1:0] LAST_ROW_POS = POS_W'(SCREEN_COLUMNS * (SCREEN_ROWS - 1));

  a_ready_needs_slot: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || out_ready))
    else $error("input taken while a result is stuck");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input taken during clearing pass");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && scrolled) |-> (cursor_after == LAST_ROW_POS && !write_dropped))
    else $error("scroll beat with wrong cursor");

  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_dropped) |-> (read_char == '0 && read_attr == '0 && !scrolled))
    else $error("dropped write beat carries data");

  a_newline_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && opcode == OP_PUT_CHAR && char_code == NEWLINE_CHAR) |=> out_valid)
    else $error("newline beat produced no result");

endmodule

bind text_console_char_writer_core tccw_checker #(
  .SCREEN_COLUMNS(SCREEN_COLUMNS),
  .SCREEN_ROWS(SCREEN_ROWS)
) u_tccw_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .opcode(opcode),
  .char_code(char_code),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .cursor_after(cursor_after),
  .read_char(read_char),
  .read_attr(read_attr),
  .scrolled(scrolled),
  .write_dropped(write_dropped)
);

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for text_console_char_writer_core (80x25 screen).
// Predicts each result from a local screen and cursor copy and checks every result beat.
// Depends on tccw_pkg and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tccw_pkg::*;

  localparam int COLS          = 80;
  localparam int ROWS          = 25;
  localparam int CELLS         = COLS * ROWS;
  localparam int LAST_ROW      = COLS * (ROWS - 1);
  localparam int SCROLL_CYCLES = CELLS + 100;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASE_ITEMS   = 222;
  localparam int PHASES        = 6;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
  } console_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor;
    logic [CHAR_W-1:0] rchar;
    logic [CHAR_W-1:0] rattr;
    logic              scrolled;
    logic              dropped;
  } console_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [CHAR_W-1:0] cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   opcode = '0;
  logic [CHAR_W-1:0] char_code = '0;
  logic [POS_W-1:0]  cell_position = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [POS_W-1:0]  cursor_after;
  logic [CHAR_W-1:0] read_char;
  logic [CHAR_W-1:0] read_attr;
  logic              scrolled;
  logic              write_dropped;

  text_console_char_writer_core #(
    .SCREEN_COLUMNS(COLS),
    .SCREEN_ROWS   (ROWS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .char_code    (char_code),
    .cell_position(cell_position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cursor_after (cursor_after),
    .read_char    (read_char),
    .read_attr    (read_attr),
    .scrolled     (scrolled),
    .write_dropped(write_dropped)
  );

  always #5 clk = ~clk;

  logic [CELL_W-1:0] screen [CELLS];
  int                model_cursor;
  logic [CHAR_W-1:0] text_attr;

  console_cmd_t    cmd_backlog[$];
  console_result_t awaited_results[$];
  int              queued_items = 0;
  int              cycle_count = 0;
  bit              failed = 1'b0;
  bit              beat_in = 1'b0;
  bit              beat_out = 1'b0;
  bit              src_calm = 1'b0;
  bit              snk_calm = 1'b0;
  int              src_wait = 0;
  int              snk_wait = 0;

  function automatic void console_reset();
    for (int i = 0; i < CELLS; i++) screen[i] = '0;
    model_cursor = 0;
    text_attr    = ATTR_RESET;
  endfunction

  function automatic console_result_t console_apply(console_cmd_t c);
    console_result_t r;
    r = '0;
    case (c.op)
      OP_PUT_CHAR: begin
        if (c.ch >= CHAR_FIRST && c.ch <= CHAR_LAST) begin
          if (model_cursor < CELLS) begin
            screen[model_cursor] = {text_attr, c.ch};
            model_cursor++;
          end else begin
            r.dropped = 1'b1;
          end
        end else if (c.ch == NEWLINE_CHAR) begin
          if (model_cursor >= LAST_ROW) begin
            for (int i = 0; i < LAST_ROW; i++) screen[i] = screen[i + COLS];
            for (int i = LAST_ROW; i < CELLS; i++) screen[i] = '0;
            model_cursor = LAST_ROW;
            r.scrolled = 1'b1;
          end else begin
            model_cursor = model_cursor - (model_cursor % COLS) + COLS;
          end
        end
      end
      OP_SET_CURSOR: model_cursor = (int'(c.pos) > CELLS) ? CELLS : int'(c.pos);
      OP_READ_CELL: begin
        if (int'(c.pos) < CELLS) {r.rattr, r.rchar} = screen[c.pos];
      end
      default: ;
    endcase
    r.cursor = model_cursor[POS_W-1:0];
    return r;
  endfunction

  function automatic int idle_draw(bit calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return CHAR_W'($urandom_range(CHAR_FIRST, CHAR_LAST));
    if (r == 7) return NEWLINE_CHAR;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  task automatic push_cmd(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch, int pos);
    console_cmd_t c;
    c.op  = op;
    c.ch  = ch;
    c.pos = pos[POS_W-1:0];
    cmd_backlog.push_back(c);
    queued_items++;
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  // driver: hold each beat until accepted, idle a random count after it
  always @(negedge clk) begin
    console_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_in) begin
      if (beat_in) src_wait = idle_draw(src_calm);
      if (src_wait > 0) begin
        src_wait--;
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        c = cmd_backlog.pop_front();
        opcode        <= c.op;
        char_code     <= c.ch;
        cell_position <= c.pos;
        in_valid      <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (beat_out) snk_wait = idle_draw(snk_calm);
    if (snk_wait > 0) begin
      snk_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    console_cmd_t    c;
    console_result_t want;
    cycle_count++;
    beat_in  = !rst && in_valid && in_ready;
    beat_out = !rst && out_valid && out_ready;
    if (beat_in) begin
      c.op  = opcode;
      c.ch  = char_code;
      c.pos = cell_position;
      awaited_results.push_back(console_apply(c));
    end
    if (beat_out) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing expected, cursor_after %0d", cursor_after);
        failed = 1'b1;
      end else begin
        want = awaited_results.pop_front();
        report_field("cursor_after", 16'(want.cursor), 16'(cursor_after));
        report_field("read_char", 16'(want.rchar), 16'(read_char));
        report_field("read_attr", 16'(want.rattr), 16'(read_attr));
        report_field("scrolled", 16'(want.scrolled), 16'(scrolled));
        report_field("write_dropped", 16'(want.dropped), 16'(write_dropped));
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [CHAR_W-1:0] attr_plan [PHASES];
    int p, n, kind, phase_start, chunk_start, chunk_target;
    attr_plan = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01};
    for (int i = 2; i < 5; i++) attr_plan[i] = CHAR_W'($urandom_range(0, 255));
    console_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_cmd(OP_READ_CELL, 8'h00, 0);
    push_cmd(OP_PUT_CHAR, 8'h41, 0);
    push_cmd(OP_PUT_CHAR, CHAR_FIRST, 0);
    push_cmd(OP_PUT_CHAR, CHAR_LAST, 0);
    push_cmd(OP_PUT_CHAR, 8'h1F, 0);
    push_cmd(OP_PUT_CHAR, 8'h80, 0);
    push_cmd(OP_PUT_CHAR, 8'hFF, 0);
    push_cmd(OP_PUT_CHAR, 8'h00, 0);
    push_cmd(OP_PUT_CHAR, NEWLINE_CHAR, 0);
    push_cmd(OP_READ_CELL, 8'h00, 0);
    push_cmd(OP_SET_CURSOR, 8'h00, 2047);
    push_cmd(OP_PUT_CHAR, 8'h78, 0);
    push_cmd(OP_READ_CELL, 8'h00, 2047);
    push_cmd(OP_PUT_CHAR, NEWLINE_CHAR, 0);
    push_cmd(OP_SET_CURSOR, 8'h00, CELLS - 1);
    push_cmd(OP_PUT_CHAR, 8'h5A, 0);
    push_cmd(OP_PUT_CHAR, 8'h51, 0);
    push_cmd(OP_READ_CELL, 8'h00, CELLS - 1);
    push_cmd(OP_SET_CURSOR, 8'h00, LAST_ROW - 1);
    push_cmd(OP_PUT_CHAR, NEWLINE_CHAR, 0);
    push_cmd(OP_PUT_CHAR, NEWLINE_CHAR, 0);
    push_cmd(OP_READ_CELL, 8'h00, LAST_ROW - 1);
    push_cmd(OP_UNUSED, 8'hAA, 'h555);
    push_cmd(OP_SET_CURSOR, 8'h00, CELLS);
    push_cmd(OP_SET_CURSOR, 8'h00, 0);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      repeat (SCROLL_CYCLES) @(posedge clk);
      @(negedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= attr_plan[ph];
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      text_attr = attr_plan[ph];

      phase_start  = queued_items;
      chunk_start  = queued_items;
      chunk_target = $urandom_range(30, 90);
      while (queued_items - phase_start < PHASE_ITEMS) begin
        if (queued_items - chunk_start >= chunk_target) begin
          wait_drained();
          src_calm     = ($urandom_range(0, 3) == 0);
          snk_calm     = ($urandom_range(0, 3) == 0);
          chunk_start  = queued_items;
          chunk_target = $urandom_range(30, 90);
        end
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
          case ($urandom_range(0, 3))
            0: p = $urandom_range(0, 2047);
            1: p = $urandom_range(0, ROWS - 1) * COLS;
            2: p = $urandom_range(CELLS - 12, CELLS);
            default: p = $urandom_range(LAST_ROW, CELLS - 1);
          endcase
          n = $urandom_range(1, 12);
          push_cmd(OP_SET_CURSOR, CHAR_W'($urandom_range(0, 255)), p);
          repeat (n) push_cmd(OP_PUT_CHAR, pick_char(), int'($urandom_range(0, 2047)));
          for (int k = 0; k < n; k++)
            push_cmd(OP_READ_CELL, CHAR_W'($urandom_range(0, 255)), p + k);
        end else if (kind < 7) begin
          p = $urandom_range(LAST_ROW - 20, CELLS);
          n = $urandom_range(0, 6);
          push_cmd(OP_SET_CURSOR, 8'h00, p);
          repeat (n) push_cmd(OP_PUT_CHAR, CHAR_W'($urandom_range(CHAR_FIRST, CHAR_LAST)), 0);
          push_cmd(OP_PUT_CHAR, NEWLINE_CHAR, 0);
          for (int k = 0; k <= n; k++) push_cmd(OP_READ_CELL, 8'h00, p - COLS + k);
          push_cmd(OP_READ_CELL, 8'h00, int'($urandom_range(LAST_ROW, CELLS - 1)));
        end else begin
          repeat ($urandom_range(1, 5))
            push_cmd(OP_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                     int'($urandom_range(0, 2047)));
        end
      end
      wait_drained();
    end

    repeat (SCROLL_CYCLES) @(posedge clk);
    if (!failed && awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/tccw_pkg.sv
sv/text_console_char_writer_core.sv
sv/tccw_checker.sv
dv/tb_top.sv
